// ----- sv/qrs_pkg.sv -----
`timescale 1ns / 1ps

package qrs_pkg;

  // Result status codes.
  localparam logic [1:0] ST_TWO    = 2'd0;
  localparam logic [1:0] ST_DOUBLE = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_ZERO_A = 2'd3;

  // One root bit per square root stage, one quotient bit per divider stage.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;

  // Cycles from the accepting edge to the edge that samples the result strobe.
  localparam int ROOT_LATENCY = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // Square root pipeline stage.
  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic signed [15:0] a;
    logic signed [31:0] bs;
    logic [63:0]        x;
    logic [33:0]        rem;
    logic [31:0]        root;
  } sq_stage_t;

  // Divider pipeline stage, two lanes sharing one divisor.
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic        neg1;
    logic        neg2;
    logic [15:0] den;
    logic [32:0] nq1;
    logic [32:0] nq2;
    logic [15:0] rem1;
    logic [15:0] rem2;
  } dv_stage_t;

endpackage

// ----- sv/quadratic_root_solver.sv -----
`timescale 1ns / 1ps

// Quadratic root solver for a*x^2 + b*x + c = 0.
// Input channel: coef_square, coef_linear and coef_const (signed Q8.8) are
// taken at a rising edge where start is high and busy is low. busy is high
// only while rst is asserted, so one item can be accepted in every cycle.
// Output channel: done is high for exactly one cycle per item, with status,
// root_first and root_second (signed Q31.16, truncated toward zero) valid in
// that same cycle. Results leave in the order the items came in.
// Throughput is one item per cycle. The pipeline holds the 32-stage square
// root pipeline (one root bit per stage) and the 33-stage restoring
// divider (one quotient bit per stage, both roots in parallel), plus
// input, multiply, discriminant, numerator and output registers.
// A synchronous reset clears every valid bit; items in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module quadratic_root_solver (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] coef_square,
  input  logic signed [15:0] coef_linear,
  input  logic signed [15:0] coef_const,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [47:0] root_first,
  output logic signed [47:0] root_second
);

  // Input registers.
  logic               in_valid;
  logic signed [15:0] in_a;
  logic signed [15:0] in_b;
  logic signed [15:0] in_c;

  // Product registers.
  logic               pr_valid;
  logic signed [15:0] pr_a;
  logic signed [31:0] pr_bs;
  logic signed [31:0] pr_bb;
  logic signed [31:0] pr_ac;

  logic signed [34:0] disc;
  logic [1:0]         disc_status;

  qrs_pkg::sq_stage_t sq [0:qrs_pkg::SQRT_STEPS];
  qrs_pkg::dv_stage_t dv [0:qrs_pkg::DIV_STEPS];

  logic signed [33:0] num1;
  logic signed [33:0] num2;

  assign busy = rst;

  // Capture the coefficients.
  always_ff @(posedge clk) begin
    in_valid <= start && !busy;
    in_a     <= coef_square;
    in_b     <= coef_linear;
    in_c     <= coef_const;
    if (rst) begin
      in_valid <= 1'b0;
    end
  end

  // Form b*b, a*c and b scaled to the root's fraction.
  always_ff @(posedge clk) begin
    pr_valid <= in_valid;
    pr_a     <= in_a;
    pr_bs    <= 32'(in_b) <<< 15;
    pr_bb    <= in_b * in_b;
    pr_ac    <= in_a * in_c;
    if (rst) begin
      pr_valid <= 1'b0;
    end
  end

  // Discriminant and classification.
  always_comb begin
    disc = 35'(pr_bb) - (35'(pr_ac) <<< 2);
    if (pr_a == 16'sd0) begin
      disc_status = qrs_pkg::ST_ZERO_A;
    end else if (disc < 35'sd0) begin
      disc_status = qrs_pkg::ST_NONE;
    end else if (disc == 35'sd0) begin
      disc_status = qrs_pkg::ST_DOUBLE;
    end else begin
      disc_status = qrs_pkg::ST_TWO;
    end
  end

  // Load the square root pipeline; the radicand is d shifted up by 30 bits.
  always_ff @(posedge clk) begin
    sq[0].valid  <= pr_valid;
    sq[0].status <= disc_status;
    sq[0].a      <= pr_a;
    sq[0].bs     <= pr_bs;
    sq[0].x      <= (disc_status == qrs_pkg::ST_TWO) ? {1'b0, disc[32:0], 30'd0} : 64'd0;
    sq[0].rem    <= '0;
    sq[0].root   <= '0;
    if (rst) begin
      sq[0].valid <= 1'b0;
    end
  end

  // Digit-by-digit square root: two radicand bits in, one root bit out per stage.
  for (genvar k = 0; k < qrs_pkg::SQRT_STEPS; k++) begin : g_sqrt
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        fits;
    qrs_pkg::sq_stage_t nxt;

    always_comb begin
      rem_sh = {sq[k].rem, sq[k].x[63:62]};
      trial  = {2'b00, sq[k].root, 2'b01};
      fits   = rem_sh >= trial;
      nxt        = sq[k];
      nxt.x      = {sq[k].x[61:0], 2'b00};
      nxt.rem    = fits ? 34'(rem_sh - trial) : rem_sh[33:0];
      nxt.root   = {sq[k].root[30:0], fits};
    end

    always_ff @(posedge clk) begin
      sq[k+1] <= nxt;
      if (rst) begin
        sq[k+1].valid <= 1'b0;
      end
    end
  end

  // Numerators S - b*2^15 and -S - b*2^15.
  always_comb begin
    num1 = $signed({2'b00, sq[qrs_pkg::SQRT_STEPS].root}) - 34'(sq[qrs_pkg::SQRT_STEPS].bs);
    num2 = -$signed({2'b00, sq[qrs_pkg::SQRT_STEPS].root}) - 34'(sq[qrs_pkg::SQRT_STEPS].bs);
  end

  // Load the divider with magnitudes; signs travel alongside.
  always_ff @(posedge clk) begin
    dv[0].valid  <= sq[qrs_pkg::SQRT_STEPS].valid;
    dv[0].status <= sq[qrs_pkg::SQRT_STEPS].status;
    dv[0].neg1   <= num1[33] ^ sq[qrs_pkg::SQRT_STEPS].a[15];
    dv[0].neg2   <= num2[33] ^ sq[qrs_pkg::SQRT_STEPS].a[15];
    dv[0].den    <= sq[qrs_pkg::SQRT_STEPS].a[15] ? 16'(-sq[qrs_pkg::SQRT_STEPS].a)
                                                  : 16'(sq[qrs_pkg::SQRT_STEPS].a);
    dv[0].nq1    <= num1[33] ? 33'(-num1) : num1[32:0];
    dv[0].nq2    <= num2[33] ? 33'(-num2) : num2[32:0];
    dv[0].rem1   <= '0;
    dv[0].rem2   <= '0;
    if (rst) begin
      dv[0].valid <= 1'b0;
    end
  end

  // Restoring division: one quotient bit per stage in each lane.
  for (genvar k = 0; k < qrs_pkg::DIV_STEPS; k++) begin : g_div
    logic [16:0] sh1;
    logic [16:0] sh2;
    logic        ge1;
    logic        ge2;
    qrs_pkg::dv_stage_t nxt;

    always_comb begin
      sh1 = {dv[k].rem1, dv[k].nq1[32]};
      sh2 = {dv[k].rem2, dv[k].nq2[32]};
      ge1 = sh1 >= {1'b0, dv[k].den};
      ge2 = sh2 >= {1'b0, dv[k].den};
      nxt      = dv[k];
      nxt.rem1 = ge1 ? 16'(sh1 - {1'b0, dv[k].den}) : sh1[15:0];
      nxt.rem2 = ge2 ? 16'(sh2 - {1'b0, dv[k].den}) : sh2[15:0];
      nxt.nq1  = {dv[k].nq1[31:0], ge1};
      nxt.nq2  = {dv[k].nq2[31:0], ge2};
    end

    always_ff @(posedge clk) begin
      dv[k+1] <= nxt;
      if (rst) begin
        dv[k+1].valid <= 1'b0;
      end
    end
  end

  // Apply signs and present the result. Quotients stay below 2^33, so the
  // 48-bit range is never exceeded.
  always_ff @(posedge clk) begin
    done   <= dv[qrs_pkg::DIV_STEPS].valid;
    status <= dv[qrs_pkg::DIV_STEPS].status;
    if (dv[qrs_pkg::DIV_STEPS].status == qrs_pkg::ST_NONE ||
        dv[qrs_pkg::DIV_STEPS].status == qrs_pkg::ST_ZERO_A) begin
      root_first  <= '0;
      root_second <= '0;
    end else begin
      root_first  <= dv[qrs_pkg::DIV_STEPS].neg1 ? -$signed(48'(dv[qrs_pkg::DIV_STEPS].nq1))
                                                 : $signed(48'(dv[qrs_pkg::DIV_STEPS].nq1));
      root_second <= dv[qrs_pkg::DIV_STEPS].neg2 ? -$signed(48'(dv[qrs_pkg::DIV_STEPS].nq2))
                                                 : $signed(48'(dv[qrs_pkg::DIV_STEPS].nq2));
    end
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule

// ----- sv/qrs_checker.sv -----
`timescale 1ns / 1ps

module qrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic signed [47:0] root_first,
  input logic signed [47:0] root_second
);

  // Every accepted item yields a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(qrs_pkg::ROOT_LATENCY) done)
    else $error("accepted item produced no result on time");

  // No result appears without an item accepted the latency earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, qrs_pkg::ROOT_LATENCY))
    else $error("result without a matching item");

  // Equations without real roots, and those with a zero square coefficient, report zero roots.
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    (done && (status == qrs_pkg::ST_NONE || status == qrs_pkg::ST_ZERO_A))
      |-> (root_first == 48'sd0 && root_second == 48'sd0))
    else $error("nonzero root with no real root");

  // A double root fills both root fields alike.
  a_double: assert property (@(posedge clk) disable iff (rst)
    (done && status == qrs_pkg::ST_DOUBLE) |-> (root_first == root_second))
    else $error("double root fields differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .root_first  (root_first),
  .root_second (root_second)
);
